// File: design/ccbc_pkg.sv
// Shared constants, codon class table and types for the codon class bias counter.
package ccbc_pkg;

  // Default widths of the window sums/running totals and of the sequence count
  localparam int COUNT_BITS_DEF  = 32;
  localparam int WINDOW_BITS_DEF = 16;

  // Fixed field and register widths
  localparam int CODON_W  = 6;
  localparam int WIN_REG_W = 16;
  localparam int WEIGHT_W = 24;
  localparam int BIAS_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [WEIGHT_W-1:0]  PRETC_WEIGHT_RESET = 24'd166819;
  localparam logic [WEIGHT_W-1:0]  SLAG_WEIGHT_RESET  = 24'd114688;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEQUENCES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRETC_WEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLAG_WEIGHT      = 2'd2;

  // Codon class bits
  localparam int CLASS_W = 7;
  localparam logic [CLASS_W-1:0] CL_P   = 7'h01;
  localparam logic [CLASS_W-1:0] CL_S   = 7'h02;
  localparam logic [CLASS_W-1:0] CL_N   = 7'h04;
  localparam logic [CLASS_W-1:0] CL_L   = 7'h08;
  localparam logic [CLASS_W-1:0] CL_NL  = 7'h0C;
  localparam logic [CLASS_W-1:0] CL_TAA = 7'h10;
  localparam logic [CLASS_W-1:0] CL_TAG = 7'h20;
  localparam logic [CLASS_W-1:0] CL_TGA = 7'h40;

  localparam int BIT_P   = 0;
  localparam int BIT_S   = 1;
  localparam int BIT_N   = 2;
  localparam int BIT_L   = 3;
  localparam int BIT_TAA = 4;
  localparam int BIT_TAG = 5;
  localparam int BIT_TGA = 6;

  // Membership of each codon, indexed by the 6-bit codon code
  localparam logic [CLASS_W-1:0] CLASS_TABLE [64] = '{
    // A
    CL_P,   CL_N,   CL_P,   CL_N,   CL_N,   CL_N,   CL_N,   CL_N,
    CL_S,   CL_L,   CL_L,   CL_L,   CL_N,   CL_N,   CL_N,   CL_N,
    // C
    CL_P,   CL_N,   CL_P,   CL_N,   CL_N,   CL_N,   CL_N,   CL_N,
    CL_S,   CL_L,   CL_S,   CL_L,   CL_N,   CL_N,   CL_N,   CL_N,
    // G
    CL_P,   CL_N,   CL_P,   CL_N,   CL_N,   CL_N,   CL_N,   CL_N,
    CL_S,   CL_L,   CL_L,   CL_L,   CL_NL,  CL_NL,  CL_NL,  CL_NL,
    // T
    CL_TAA, CL_P,   CL_TAG, CL_P,   CL_S,   CL_L,   CL_S,   CL_L,
    CL_TGA, CL_P,   CL_P,   CL_P,   CL_S,   CL_N,   CL_S,   CL_N
  };

  // Status from the ratio unit to the sequencer
  typedef struct packed {
    logic done;
    logic saturated;
  } ratio_stat_t;

endpackage

// File: design/ccbc_ratio_unit.sv
// Iterative weight*num/den unit: shift-add multiply, then restoring divide, one shared adder.
module ccbc_ratio_unit #(
  parameter int COUNT_BITS = ccbc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ccbc_pkg::WEIGHT_W-1:0]     weight_i,
  input  logic [COUNT_BITS-1:0]             num_i,
  input  logic [COUNT_BITS-1:0]             den_i,
  output ccbc_pkg::ratio_stat_t             stat_o,
  output logic [ccbc_pkg::BIAS_W-1:0]       quot_o
);

  localparam int WB     = ccbc_pkg::WEIGHT_W;
  localparam int QW     = ccbc_pkg::BIAS_W;
  localparam int PROD_W = COUNT_BITS + WB;
  localparam int UW     = PROD_W + 1;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [1:0] {
    R_IDLE,
    R_MUL,
    R_DIV
  } rstate_e;

  rstate_e             state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [WB-1:0]       w_q;
  logic [COUNT_BITS-1:0] num_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [PROD_W-1:0]   acc_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [QW-1:0]       quot_q;
  logic                sat_q;
  logic                done_q;

  logic [UW-1:0]       op_a;
  logic [UW-1:0]       op_b;
  logic                sub;
  logic [UW:0]         sum;
  logic                ge;
  logic [COUNT_BITS:0] shifted_rem;

  // Shared adder: accumulate in multiply, trial subtract in divide
  always_comb begin
    shifted_rem = {rem_q, acc_q[PROD_W-1]};
    if (state_q == R_DIV) begin
      op_a = UW'(shifted_rem);
      op_b = UW'(den_q);
      sub  = 1'b1;
    end else begin
      op_a = {acc_q, 1'b0};
      op_b = w_q[WB-1] ? UW'(num_q) : '0;
      sub  = 1'b0;
    end
    sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (UW+1)'(sub);
    ge  = sum[UW];
  end

  // Sequence the multiply and divide steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      w_q     <= '0;
      num_q   <= '0;
      den_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      quot_q  <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      // flag the last divide step
      done_q <= (state_q == R_DIV) && (cnt_q == '0);
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            w_q     <= weight_i;
            num_q   <= num_i;
            den_q   <= den_i;
            acc_q   <= '0;
            rem_q   <= '0;
            quot_q  <= '0;
            sat_q   <= 1'b0;
            cnt_q   <= CNT_W'(WB - 1);
            state_q <= R_MUL;
          end
        end
        R_MUL: begin
          acc_q <= sum[PROD_W-1:0];
          w_q   <= {w_q[WB-2:0], 1'b0};
          if (cnt_q == '0) begin
            cnt_q   <= CNT_W'(PROD_W - 1);
            state_q <= R_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        R_DIV: begin
          // remainder stays below the divisor, so it fits the count width
          rem_q  <= ge ? sum[COUNT_BITS-1:0] : shifted_rem[COUNT_BITS-1:0];
          acc_q  <= {acc_q[PROD_W-2:0], 1'b0};
          quot_q <= {quot_q[QW-2:0], ge};
          if (quot_q[QW-1]) begin
            sat_q <= 1'b1;
          end
          if (cnt_q == '0) begin
            state_q <= R_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  assign stat_o.done      = done_q;
  assign stat_o.saturated = sat_q;
  assign quot_o           = quot_q;

endmodule

// File: design/codon_class_bias_counter.sv
// Top level: codon classification, window sums, running totals and bias sequencer.
//
// Input channel (s_axis): one codon per item; tdata = codon[5:0], codon_ok[6],
// zero pad [7]; tlast marks the last codon of a sequence.
// Output channel (m_axis): one result item per completed window of sequences.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 window length, 1 pre-termination weight, 2 SLAG weight); the user must
// write only while idle, as the block itself does not enforce it. An item
// that does not close a window is counted and the next item may follow at
// once. The item that closes a window holds s_axis_tready low while the
// ratio unit works out both biases one after the other through its shared
// adder; a zero denominator skips the ratio unit for that bias. The result
// then goes to an output register in state T_LOAD and the block is ready
// again. If the receiver still holds an earlier result, the block waits for
// it.
// Reset clears all sums, totals and the sequence count, restores the register
// defaults and empties the output register.
module codon_class_bias_counter #(
  parameter int COUNT_BITS  = ccbc_pkg::COUNT_BITS_DEF,
  parameter int WINDOW_BITS = ccbc_pkg::WINDOW_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // codon[5:0], codon_ok[6], pad[7]
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pretc_bias[31:0], slag_bias[63:32], pretc_zero_denominator[64],
  // slag_zero_denominator[65], taa_seen[97:66], tag_seen[129:98],
  // tga_seen[161:130], bad_codons_seen[193:162], pad[199:194]
  output logic [199:0]                        m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [ccbc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccbc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CW  = COUNT_BITS;
  localparam int WW  = WINDOW_BITS;
  localparam int TW  = (WW > ccbc_pkg::WIN_REG_W) ? WW : ccbc_pkg::WIN_REG_W;
  localparam int EW  = (CW > 32) ? CW : 32;
  localparam int QW  = ccbc_pkg::BIAS_W;
  localparam logic [TW-1:0] WIN_MAX = TW'({WW{1'b1}});

  typedef enum logic [2:0] {
    T_IDLE,
    T_P_START,
    T_P_WAIT,
    T_S_START,
    T_S_WAIT,
    T_LOAD
  } tstate_e;

  // Configuration registers
  logic [ccbc_pkg::WIN_REG_W-1:0] window_q;
  logic [ccbc_pkg::WEIGHT_W-1:0]  pretc_weight_q;
  logic [ccbc_pkg::WEIGHT_W-1:0]  slag_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= ccbc_pkg::WINDOW_RESET;
      pretc_weight_q <= ccbc_pkg::PRETC_WEIGHT_RESET;
      slag_weight_q  <= ccbc_pkg::SLAG_WEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccbc_pkg::REG_WINDOW_SEQUENCES: window_q <= cfg_data_i[ccbc_pkg::WIN_REG_W-1:0];
        ccbc_pkg::REG_PRETC_WEIGHT:     pretc_weight_q <= cfg_data_i;
        ccbc_pkg::REG_SLAG_WEIGHT:      slag_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tstate_e          state_q;
  logic [CW-1:0]    p_sum_q, s_sum_q, n_sum_q, l_sum_q;
  logic [CW-1:0]    taa_q, tag_q, tga_q, bad_q;
  logic [WW-1:0]    seq_q;
  logic [QW-1:0]    p_bias_q, s_bias_q;
  logic             p_zero_q, s_zero_q;
  logic [199:0]     out_data_q;
  logic             out_vld_q;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
    return (en && (v != '1)) ? v + CW'(1) : v;
  endfunction

  function automatic logic [31:0] clip32(input logic [CW-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    return (ve > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ve[31:0];
  endfunction

  // Classify the codon
  logic                          accept;
  logic [ccbc_pkg::CODON_W-1:0]  codon;
  logic                          codon_ok;
  logic [ccbc_pkg::CLASS_W-1:0]  cls;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign codon    = s_axis_tdata[ccbc_pkg::CODON_W-1:0];
  assign codon_ok = s_axis_tdata[ccbc_pkg::CODON_W];
  assign cls      = codon_ok ? ccbc_pkg::CLASS_TABLE[codon] : '0;

  // Window length check: zero counts as one, clipped to the counter range
  logic [WW-1:0] seq_inc;
  logic [TW-1:0] target;
  logic          window_done;

  always_comb begin
    seq_inc = (seq_q != '1) ? seq_q + WW'(1) : seq_q;
    target  = (window_q == '0) ? TW'(1) : TW'(window_q);
    if (target > WIN_MAX) begin
      target = WIN_MAX;
    end
    window_done = s_axis_tlast && (TW'(seq_inc) >= target);
  end

  // Ratio unit operands, chosen by phase
  logic                          ratio_start;
  logic                          slag_phase;
  logic [ccbc_pkg::WEIGHT_W-1:0] ratio_weight;
  logic [CW-1:0]                 ratio_num;
  logic [CW-1:0]                 ratio_den;
  ccbc_pkg::ratio_stat_t         ratio_stat;
  logic [QW-1:0]                 ratio_quot;
  logic [QW-1:0]                 ratio_res;

  assign slag_phase   = (state_q == T_S_START);
  assign ratio_weight = slag_phase ? slag_weight_q : pretc_weight_q;
  assign ratio_num    = slag_phase ? s_sum_q : p_sum_q;
  assign ratio_den    = slag_phase ? l_sum_q : n_sum_q;
  assign ratio_start  = ((state_q == T_P_START) && (n_sum_q != '0)) ||
                        ((state_q == T_S_START) && (l_sum_q != '0));
  assign ratio_res    = ratio_stat.saturated ? '1 : ratio_quot;

  ccbc_ratio_unit #(
    .COUNT_BITS(CW)
  ) u_ratio (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ratio_start),
    .weight_i (ratio_weight),
    .num_i    (ratio_num),
    .den_i    (ratio_den),
    .stat_o   (ratio_stat),
    .quot_o   (ratio_quot)
  );

  // Sequencer, sums, totals and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      p_sum_q    <= '0;
      s_sum_q    <= '0;
      n_sum_q    <= '0;
      l_sum_q    <= '0;
      taa_q      <= '0;
      tag_q      <= '0;
      tga_q      <= '0;
      bad_q      <= '0;
      seq_q      <= '0;
      p_bias_q   <= '0;
      s_bias_q   <= '0;
      p_zero_q   <= 1'b0;
      s_zero_q   <= 1'b0;
      out_data_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded now
      if (out_vld_q && m_axis_tready && (state_q != T_LOAD)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (accept) begin
            p_sum_q <= sat_inc(p_sum_q, cls[ccbc_pkg::BIT_P]);
            s_sum_q <= sat_inc(s_sum_q, cls[ccbc_pkg::BIT_S]);
            n_sum_q <= sat_inc(n_sum_q, cls[ccbc_pkg::BIT_N]);
            l_sum_q <= sat_inc(l_sum_q, cls[ccbc_pkg::BIT_L]);
            taa_q   <= sat_inc(taa_q, cls[ccbc_pkg::BIT_TAA]);
            tag_q   <= sat_inc(tag_q, cls[ccbc_pkg::BIT_TAG]);
            tga_q   <= sat_inc(tga_q, cls[ccbc_pkg::BIT_TGA]);
            bad_q   <= sat_inc(bad_q, !codon_ok);
            if (s_axis_tlast) begin
              seq_q <= seq_inc;
            end
            if (window_done) begin
              state_q <= T_P_START;
            end
          end
        end
        T_P_START: begin
          if (n_sum_q == '0) begin
            p_bias_q <= '0;
            p_zero_q <= 1'b1;
            state_q  <= T_S_START;
          end else begin
            p_zero_q <= 1'b0;
            state_q  <= T_P_WAIT;
          end
        end
        T_P_WAIT: begin
          if (ratio_stat.done) begin
            p_bias_q <= ratio_res;
            state_q  <= T_S_START;
          end
        end
        T_S_START: begin
          if (l_sum_q == '0) begin
            s_bias_q <= '0;
            s_zero_q <= 1'b1;
            state_q  <= T_LOAD;
          end else begin
            s_zero_q <= 1'b0;
            state_q  <= T_S_WAIT;
          end
        end
        T_S_WAIT: begin
          if (ratio_stat.done) begin
            s_bias_q <= ratio_res;
            state_q  <= T_LOAD;
          end
        end
        T_LOAD: begin
          // hold until the output register is free, then clear the window
          if (!out_vld_q || m_axis_tready) begin
            out_data_q <= {6'd0, clip32(bad_q), clip32(tga_q), clip32(tag_q),
                           clip32(taa_q), s_zero_q, p_zero_q, s_bias_q, p_bias_q};
            out_vld_q  <= 1'b1;
            p_sum_q    <= '0;
            s_sum_q    <= '0;
            n_sum_q    <= '0;
            l_sum_q    <= '0;
            seq_q      <= '0;
            state_q    <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == T_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sim/codon_class_bias_counter_tb.sv
// Self-checking testbench for the codon class bias counter: directed and random codon streams.
module codon_class_bias_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RATIO_CYCLES    =
    2 * (ccbc_pkg::WEIGHT_W + ccbc_pkg::COUNT_BITS_DEF + ccbc_pkg::WEIGHT_W + 1);
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RUN_LIMIT_NS    = 12_000_000;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Index with no register behind it; writes there must change nothing
  localparam logic [ccbc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [31:0]                   COUNT_MAX  = '1;
  localparam logic [15:0]                   SEQ_MAX    = '1;
  localparam logic [ccbc_pkg::WEIGHT_W-1:0] WEIGHT_MAX = '1;

  typedef struct packed {
    logic [31:0] pretc_bias;
    logic [31:0] slag_bias;
    logic        pretc_zero;
    logic        slag_zero;
    logic [31:0] taa_seen;
    logic [31:0] tag_seen;
    logic [31:0] tga_seen;
    logic [31:0] bad_seen;
  } window_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic [7:0]                      s_axis_tdata;
  logic                            s_axis_tlast;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [199:0]                    m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_we_i;
  logic [ccbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ccbc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  codon_class_bias_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted register and counter state
  logic [ccbc_pkg::WIN_REG_W-1:0] win_len = ccbc_pkg::WINDOW_RESET;
  logic [ccbc_pkg::WEIGHT_W-1:0]  pretc_w = ccbc_pkg::PRETC_WEIGHT_RESET;
  logic [ccbc_pkg::WEIGHT_W-1:0]  slag_w  = ccbc_pkg::SLAG_WEIGHT_RESET;
  logic [31:0] p_sum = '0, s_sum = '0, n_sum = '0, l_sum = '0;
  logic [31:0] taa_cnt = '0, tag_cnt = '0, tga_cnt = '0, bad_cnt = '0;
  logic [15:0] seq_cnt = '0;

  window_result_t expected_biases[$];
  int  errors = 0;
  bit  src_idle_en = 1'b0;
  bit  sink_idle_en = 1'b0;
  bit  hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[codon_class_bias_counter] ERROR");
    $finish;
  end

  // Class membership by bases: first base in bits 5..4, third in bits 1..0
  function automatic logic [ccbc_pkg::CLASS_W-1:0] codon_class(logic [5:0] codon);
    logic [1:0] b1, b2, b3;
    logic       purine3;
    b1 = codon[5:4];
    b2 = codon[3:2];
    b3 = codon[1:0];
    purine3 = ~b3[0];
    case ({b1, b2})
      {BASE_A, BASE_A}, {BASE_C, BASE_A}, {BASE_G, BASE_A}: begin
        codon_class = purine3 ? ccbc_pkg::CL_P : ccbc_pkg::CL_N;
      end
      {BASE_A, BASE_G}, {BASE_G, BASE_G}: begin
        codon_class = (b3 == BASE_A) ? ccbc_pkg::CL_S : ccbc_pkg::CL_L;
      end
      {BASE_C, BASE_G}, {BASE_T, BASE_C}: begin
        codon_class = purine3 ? ccbc_pkg::CL_S : ccbc_pkg::CL_L;
      end
      {BASE_G, BASE_T}: codon_class = ccbc_pkg::CL_NL;
      {BASE_T, BASE_A}: begin
        codon_class = (b3 == BASE_A) ? ccbc_pkg::CL_TAA :
                      (b3 == BASE_G) ? ccbc_pkg::CL_TAG : ccbc_pkg::CL_P;
      end
      {BASE_T, BASE_G}: codon_class = (b3 == BASE_A) ? ccbc_pkg::CL_TGA : ccbc_pkg::CL_P;
      {BASE_T, BASE_T}: codon_class = purine3 ? ccbc_pkg::CL_S : ccbc_pkg::CL_N;
      default: codon_class = ccbc_pkg::CL_N;
    endcase
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  // floor(weight * num / den) in Q16.16, clipped to 32 bits
  function automatic logic [31:0] weighted_ratio(logic [ccbc_pkg::WEIGHT_W-1:0] w,
                                                 logic [31:0] num, logic [31:0] den);
    logic [63:0] prod, quo;
    prod = 64'(w) * 64'(num);
    quo = prod / 64'(den);
    return (quo > 64'hFFFF_FFFF) ? COUNT_MAX : quo[31:0];
  endfunction

  // Count one accepted codon; queue the window result when a window closes
  task automatic count_codon(logic [5:0] codon, logic ok, logic seq_end);
    logic [ccbc_pkg::CLASS_W-1:0] cls;
    logic [15:0]                  target;
    window_result_t               res;
    cls = codon_class(codon);
    if (ok) begin
      if (cls[ccbc_pkg::BIT_P])   p_sum   = sat_inc(p_sum);
      if (cls[ccbc_pkg::BIT_S])   s_sum   = sat_inc(s_sum);
      if (cls[ccbc_pkg::BIT_N])   n_sum   = sat_inc(n_sum);
      if (cls[ccbc_pkg::BIT_L])   l_sum   = sat_inc(l_sum);
      if (cls[ccbc_pkg::BIT_TAA]) taa_cnt = sat_inc(taa_cnt);
      if (cls[ccbc_pkg::BIT_TAG]) tag_cnt = sat_inc(tag_cnt);
      if (cls[ccbc_pkg::BIT_TGA]) tga_cnt = sat_inc(tga_cnt);
    end else begin
      bad_cnt = sat_inc(bad_cnt);
    end
    if (!seq_end) return;
    if (seq_cnt != SEQ_MAX) seq_cnt = seq_cnt + 16'd1;
    target = (win_len == '0) ? 16'd1 : win_len;
    if (seq_cnt < target) return;
    res.pretc_zero = (n_sum == '0);
    res.pretc_bias = res.pretc_zero ? '0 : weighted_ratio(pretc_w, p_sum, n_sum);
    res.slag_zero  = (l_sum == '0);
    res.slag_bias  = res.slag_zero ? '0 : weighted_ratio(slag_w, s_sum, l_sum);
    res.taa_seen   = taa_cnt;
    res.tag_seen   = tag_cnt;
    res.tga_seen   = tga_cnt;
    res.bad_seen   = bad_cnt;
    expected_biases = {expected_biases, res};
    p_sum = '0;
    s_sum = '0;
    n_sum = '0;
    l_sum = '0;
    seq_cnt = '0;
  endtask

  task automatic report_error(string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s mismatch: got 0x%08h, expected 0x%08h", name, got, want));
    end
  endtask

  // Predict on every accepted codon item
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      count_codon(s_axis_tdata[5:0], s_axis_tdata[6], s_axis_tlast);
    end
  end

  // Check every accepted result item against the oldest prediction
  always @(posedge clk_i) begin : result_check
    window_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pretc_bias = m_axis_tdata[31:0];
      got.slag_bias  = m_axis_tdata[63:32];
      got.pretc_zero = m_axis_tdata[64];
      got.slag_zero  = m_axis_tdata[65];
      got.taa_seen   = m_axis_tdata[97:66];
      got.tag_seen   = m_axis_tdata[129:98];
      got.tga_seen   = m_axis_tdata[161:130];
      got.bad_seen   = m_axis_tdata[193:162];
      if (expected_biases.size() == 0) begin
        report_error($sformatf("result item with none expected, pretc_bias 0x%08h",
                               got.pretc_bias));
      end else begin
        want = expected_biases.pop_front();
        compare_field("pretc_bias", got.pretc_bias, want.pretc_bias);
        compare_field("slag_bias", got.slag_bias, want.slag_bias);
        compare_field("pretc_zero_denominator", 32'(got.pretc_zero), 32'(want.pretc_zero));
        compare_field("slag_zero_denominator", 32'(got.slag_zero), 32'(want.slag_zero));
        compare_field("taa_seen", got.taa_seen, want.taa_seen);
        compare_field("tag_seen", got.tag_seen, want.tag_seen);
        compare_field("tga_seen", got.tga_seen, want.tga_seen);
        compare_field("bad_codons_seen", got.bad_seen, want.bad_seen);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one codon item, with an optional idle burst first; return once accepted
  task automatic send_codon(logic [5:0] codon, logic ok, logic seq_end);
    int gap;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ok, codon};
    s_axis_tlast  <= seq_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_biases.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers (block idle only); junk above the window field is dropped
  task automatic program_regs(logic [ccbc_pkg::WIN_REG_W-1:0] win,
                              logic [ccbc_pkg::WEIGHT_W-1:0] pw,
                              logic [ccbc_pkg::WEIGHT_W-1:0] sw);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ccbc_pkg::REG_WINDOW_SEQUENCES;
    cfg_data_i <= {8'($urandom), win};
    @(negedge clk_i);
    cfg_idx_i  <= ccbc_pkg::REG_PRETC_WEIGHT;
    cfg_data_i <= pw;
    @(negedge clk_i);
    cfg_idx_i  <= ccbc_pkg::REG_SLAG_WEIGHT;
    cfg_data_i <= sw;
    @(negedge clk_i);
    cfg_idx_i  <= REG_SPARE;
    cfg_data_i <= ccbc_pkg::CFG_DATA_W'($urandom);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    win_len = win;
    pretc_w = pw;
    slag_w  = sw;
  endtask

  function automatic logic [5:0] codon_of_class(logic [ccbc_pkg::CLASS_W-1:0] cls);
    logic [5:0] c;
    do c = 6'($urandom_range(0, 63)); while (codon_class(c) != cls);
    return c;
  endfunction

  function automatic logic [ccbc_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return WEIGHT_MAX;
      default: return ccbc_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  // Zero-length window acts as one; empty denominators raise both flags
  task automatic test_empty_windows();
    program_regs('0, ccbc_pkg::PRETC_WEIGHT_RESET, ccbc_pkg::SLAG_WEIGHT_RESET);
    send_codon(6'd0, 1'b1, 1'b1);
    send_codon(6'($urandom), 1'b0, 1'b1);
    settle();
  endtask

  // Stop codons, the GTN double class and the extreme weights
  task automatic test_class_sums();
    program_regs(16'd1, WEIGHT_MAX, '0);
    send_codon(6'd48, 1'b1, 1'b0);
    send_codon(6'd50, 1'b1, 1'b0);
    send_codon(6'd56, 1'b1, 1'b0);
    send_codon(6'd47, 1'b1, 1'b0);
    send_codon(6'd24, 1'b1, 1'b0);
    send_codon(6'd63, 1'b1, 1'b0);
    send_codon(6'd0, 1'b1, 1'b1);
    settle();
    program_regs(16'd1, '0, WEIGHT_MAX);
    send_codon(6'd40, 1'b1, 1'b0);
    send_codon(6'd41, 1'b1, 1'b0);
    send_codon(6'd63, 1'b0, 1'b0);
    send_codon(6'd52, 1'b1, 1'b1);
    settle();
  endtask

  // Longest window, then lower it mid-window: next sequence end must emit
  task automatic test_window_shrink();
    program_regs(SEQ_MAX, ccbc_pkg::PRETC_WEIGHT_RESET, ccbc_pkg::SLAG_WEIGHT_RESET);
    send_codon(6'd1, 1'b1, 1'b1);
    send_codon(6'd32, 1'b1, 1'b0);
    send_codon(6'd14, 1'b1, 1'b1);
    send_codon(6'd51, 1'b1, 1'b1);
    settle();
    program_regs(16'd2, ccbc_pkg::PRETC_WEIGHT_RESET, ccbc_pkg::SLAG_WEIGHT_RESET);
    send_codon(6'd6, 1'b1, 1'b1);
    settle();
  endtask

  // Many P and S codons over a single codon in both N and L drive both biases into saturation
  task automatic test_saturation();
    int p_left, s_left;
    program_regs(16'd1, WEIGHT_MAX, WEIGHT_MAX);
    p_left = 260;
    s_left = 260;
    while (p_left + s_left > 0) begin
      if (p_left > 0 && (s_left == 0 || $urandom_range(0, 1) == 1)) begin
        send_codon(codon_of_class(ccbc_pkg::CL_P), 1'b1, 1'b0);
        p_left--;
      end else begin
        send_codon(codon_of_class(ccbc_pkg::CL_S), 1'b1, 1'b0);
        s_left--;
      end
    end
    send_codon(codon_of_class(ccbc_pkg::CL_NL), 1'b1, 1'b1);
    settle();
  endtask

  // Hold the receiver off while closing windows back to back, so the input stalls
  task automatic test_backpressure();
    program_regs(16'd1, pick_weight(), pick_weight());
    hold_off_req = 1'b1;
    repeat (12) begin
      send_codon(6'($urandom), 1'b1, 1'b0);
      send_codon(6'($urandom), 1'b1, 1'b1);
    end
    settle();
  endtask

  // Random settings per phase, random sequences of random codons
  task automatic test_random_traffic(int phases, int items_per_phase);
    logic [ccbc_pkg::WIN_REG_W-1:0] win;
    repeat (phases) begin
      case ($urandom_range(0, 5))
        0: win = '0;
        1: win = 16'd1;
        default: win = ccbc_pkg::WIN_REG_W'($urandom_range(1, 6));
      endcase
      program_regs(win, pick_weight(), pick_weight());
      repeat (items_per_phase) begin
        send_codon(6'($urandom), 1'($urandom_range(0, 11) != 0),
                   1'($urandom_range(0, 4) == 0));
      end
      settle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_empty_windows();
    test_class_sums();
    test_window_shrink();
    test_saturation();
    test_backpressure();
    test_random_traffic(6, 160);

    // Closing stretch at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(2, 100);

    settle();
    repeat (RATIO_CYCLES + 16) @(posedge clk_i);
    if (errors == 0 && expected_biases.size() == 0) begin
      $display("[codon_class_bias_counter] OK");
    end else begin
      $display("[codon_class_bias_counter] ERROR");
    end
    $finish;
  end

endmodule
